// File: hw/rtl/audio_click_detector_top_defines.svh
// assertion macros for the click detector
// used by audio_click_detector_top, needs clk and rst_n in scope
`ifndef AUDIO_CLICK_DETECTOR_TOP_DEFINES_SVH
`define AUDIO_CLICK_DETECTOR_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define ACD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies result on the next edge
`define ACD_ASSERT_NEXT(lbl, trig, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) else $error(msg);

`endif

// File: hw/rtl/acd_pkg.sv
// shared types and constants for the click detector
// no dependencies
package acd_pkg;

  localparam int WINDOW_FRAMES_DEF = 120;

  localparam logic [1:0] CMD_STEREO = 2'd0;
  localparam logic [1:0] CMD_MONO   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_RATIO  = 2'd1;
  localparam logic [1:0] REG_SOFT   = 2'd2;
  localparam logic [1:0] REG_HARD   = 2'd3;

  localparam logic [7:0]  RATIO_RST = 8'd8;
  localparam logic [15:0] SOFT_RST  = 16'd10000;
  localparam logic [15:0] HARD_RST  = 16'd20000;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 136;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMP_DIFF,
    ST_SMP_SQ,
    ST_SMP_ACC,
    ST_MED_RDI,
    ST_MED_PIV,
    ST_MED_RDJ,
    ST_MED_CMP,
    ST_MED_CHK,
    ST_ANOM_MUL,
    ST_ANOM_CMP,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_RING_WR,
    ST_OUT
  } state_t;

endpackage

// File: hw/rtl/audio_click_detector_top.sv
// click detector for a stereo and a mono stream, one sequencer over shared units
// depends on acd_pkg and audio_click_detector_top_defines.svh
//
// channel | direction | content
// in_     | slave     | tuser: command; tdata: left_sample, right_sample
// out_    | master    | tdata: anomaly flags, peaks, medians, mean squares
// cfg_    | write     | enable, peak_ratio, soft_floor, hard_limit
//
// sample: diff step, plus square and accumulate once primed; clear: on acceptance
// tick: median scan over the ring memories, per pivot a read and a compare pass,
// then anomaly test, up to two 64-step restoring divisions, ring write and output
// rst_n clears control state, counters and config; the ring needs no clearing pass
// in_tready is low while an item is being worked; a result waits in the output
// register and a further tick stalls only at its own final step
`include "audio_click_detector_top_defines.svh"

module audio_click_detector_top #(
  parameter int WINDOW_FRAMES = acd_pkg::WINDOW_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [acd_pkg::IN_DATA_W-1:0]  in_tdata,   // left_sample, right_sample
  input  logic [1:0]                     in_tuser,   // command
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // stereo_anomaly, mono_anomaly, stereo_peak, mono_peak, stereo_median,
  // mono_median, stereo_mean_square, mono_mean_square, zero pad
  output logic [acd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import acd_pkg::*;

  localparam int IDX_W = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
  localparam int CNT_W = $clog2(WINDOW_FRAMES + 1);

  state_t state_r, state_nxt;

  logic        enable_r;
  logic [7:0]  ratio_r;
  logic [15:0] soft_r, hard_r;

  logic [1:0]         cmd_r;
  logic signed [15:0] in_l_r, in_rt_r;
  logic signed [15:0] s_last_l_r, s_last_rt_r, m_last_r;
  logic               s_primed_r, m_primed_r;

  logic [15:0] s_peak_r, m_peak_r;
  logic [63:0] s_sum_r, m_sum_r;
  logic [31:0] s_cnt_r, m_cnt_r;

  logic [IDX_W-1:0] head_r;
  logic [CNT_W-1:0] fill_r;

  logic [15:0] step_r;
  logic [31:0] sq_r;

  logic [15:0] s_ring [WINDOW_FRAMES];
  logic [15:0] m_ring [WINDOW_FRAMES];
  logic [15:0] s_rd_r, m_rd_r;
  logic [IDX_W-1:0] mem_addr;
  logic             mem_we;

  logic [IDX_W-1:0] i_r, j_r;
  logic [15:0]      s_piv_r, m_piv_r, s_med_r, m_med_r;
  logic [CNT_W-1:0] s_less_r, s_leq_r, m_less_r, m_leq_r;
  logic             s_found_r, m_found_r;

  logic [23:0] s_prod_r, m_prod_r;
  logic        s_anom_r, m_anom_r;

  logic [63:0] dvd_r;
  logic [31:0] dsr_r, rem_r;
  logic [5:0]  dcnt_r;
  logic        div_sel_r;
  logic [31:0] s_ms_r, m_ms_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // step datapath
  logic signed [16:0] dl, dr, dm;
  logic [15:0] al, ar, am, d_now;
  always_comb begin
    dl = {in_l_r[15], in_l_r} - {s_last_l_r[15], s_last_l_r};
    dr = {in_rt_r[15], in_rt_r} - {s_last_rt_r[15], s_last_rt_r};
    dm = {in_l_r[15], in_l_r} - {m_last_r[15], m_last_r};
    al = dl[16] ? 16'(-dl) : dl[15:0];
    ar = dr[16] ? 16'(-dr) : dr[15:0];
    am = dm[16] ? 16'(-dm) : dm[15:0];
    if (cmd_r == CMD_MONO) begin
      d_now = am;
    end else begin
      d_now = (al > ar) ? al : ar;
    end
  end

  // median helpers
  logic [CNT_W-1:0] half_k;
  logic             j_last, i_last, s_hit, m_hit;
  always_comb begin
    half_k = fill_r >> 1;
    j_last = (CNT_W'(j_r) == fill_r - 1'b1);
    i_last = (CNT_W'(i_r) == fill_r - 1'b1);
    s_hit  = !s_found_r && (s_less_r <= half_k) && (half_k < s_leq_r);
    m_hit  = !m_found_r && (m_less_r <= half_k) && (half_k < m_leq_r);
  end

  // divider step
  logic [32:0] rem_sh, rem_sub;
  logic        q_bit;
  logic [63:0] dvd_shift;
  always_comb begin
    rem_sh    = {rem_r, dvd_r[63]};
    rem_sub   = rem_sh - {1'b0, dsr_r};
    q_bit     = (rem_sh >= {1'b0, dsr_r});
    dvd_shift = {dvd_r[62:0], q_bit};
  end

  logic [31:0] cur_cnt;
  assign cur_cnt = div_sel_r ? m_cnt_r : s_cnt_r;
  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;
  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            CMD_STEREO, CMD_MONO: state_nxt = enable_r ? ST_SMP_DIFF : ST_IDLE;
            CMD_TICK: begin
              if (!enable_r) state_nxt = ST_IDLE;
              else if (fill_r == '0) state_nxt = ST_ANOM_MUL;
              else state_nxt = ST_MED_RDI;
            end
            CMD_CLEAR: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SMP_DIFF: begin
        if ((cmd_r == CMD_MONO) ? m_primed_r : s_primed_r) state_nxt = ST_SMP_SQ;
        else state_nxt = ST_IDLE;
      end
      ST_SMP_SQ:  state_nxt = ST_SMP_ACC;
      ST_SMP_ACC: state_nxt = ST_IDLE;
      ST_MED_RDI: state_nxt = ST_MED_PIV;
      ST_MED_PIV: state_nxt = ST_MED_RDJ;
      ST_MED_RDJ: state_nxt = ST_MED_CMP;
      ST_MED_CMP: state_nxt = j_last ? ST_MED_CHK : ST_MED_RDJ;
      ST_MED_CHK: begin
        if (i_last || ((s_found_r || s_hit) && (m_found_r || m_hit))) begin
          state_nxt = ST_ANOM_MUL;
        end else begin
          state_nxt = ST_MED_RDI;
        end
      end
      ST_ANOM_MUL: state_nxt = ST_ANOM_CMP;
      ST_ANOM_CMP: state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: begin
        if (cur_cnt == '0) state_nxt = div_sel_r ? ST_RING_WR : ST_DIV_INIT;
        else state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (dcnt_r == 6'd63) state_nxt = div_sel_r ? ST_RING_WR : ST_DIV_INIT;
      end
      ST_RING_WR: state_nxt = ST_OUT;
      ST_OUT:     state_nxt = out_free ? ST_IDLE : ST_OUT;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    mem_we    = (state_r == ST_RING_WR);
    if (state_r == ST_RING_WR) mem_addr = head_r;
    else if (state_r == ST_MED_RDI) mem_addr = i_r;
    else mem_addr = j_r;
  end

  // ring memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      s_ring[mem_addr] <= s_peak_r;
      m_ring[mem_addr] <= m_peak_r;
    end
    s_rd_r <= s_ring[mem_addr];
    m_rd_r <= m_ring[mem_addr];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      ratio_r  <= RATIO_RST;
      soft_r   <= SOFT_RST;
      hard_r   <= HARD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: enable_r <= cfg_wdata[0];
        REG_RATIO:  ratio_r  <= cfg_wdata[7:0];
        REG_SOFT:   soft_r   <= cfg_wdata;
        REG_HARD:   hard_r   <= cfg_wdata;
      endcase
    end
  end

  // datapath and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      s_primed_r   <= 1'b0;
      m_primed_r   <= 1'b0;
      s_last_l_r   <= '0;
      s_last_rt_r  <= '0;
      m_last_r     <= '0;
      s_peak_r     <= '0;
      m_peak_r     <= '0;
      s_sum_r      <= '0;
      m_sum_r      <= '0;
      s_cnt_r      <= '0;
      m_cnt_r      <= '0;
      head_r       <= '0;
      fill_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tvalid_r && out_tready && state_r != ST_OUT) out_tvalid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r     <= in_tuser;
            in_l_r    <= in_tdata[15:0];
            in_rt_r   <= in_tdata[31:16];
            i_r       <= '0;
            s_found_r <= 1'b0;
            m_found_r <= 1'b0;
            s_med_r   <= '0;
            m_med_r   <= '0;
            if (in_tuser == CMD_CLEAR) begin
              s_primed_r  <= 1'b0;
              m_primed_r  <= 1'b0;
              s_last_l_r  <= '0;
              s_last_rt_r <= '0;
              m_last_r    <= '0;
              head_r      <= '0;
              fill_r      <= '0;
            end
            if (in_tuser == CMD_CLEAR || (in_tuser == CMD_TICK && !enable_r)) begin
              s_peak_r <= '0;
              m_peak_r <= '0;
              s_sum_r  <= '0;
              m_sum_r  <= '0;
              s_cnt_r  <= '0;
              m_cnt_r  <= '0;
            end
          end
        end
        ST_SMP_DIFF: begin
          step_r <= d_now;
          if (cmd_r == CMD_MONO) begin
            m_last_r   <= in_l_r;
            m_primed_r <= 1'b1;
          end else begin
            s_last_l_r  <= in_l_r;
            s_last_rt_r <= in_rt_r;
            s_primed_r  <= 1'b1;
          end
        end
        ST_SMP_SQ: sq_r <= step_r * step_r;
        ST_SMP_ACC: begin
          if (cmd_r == CMD_MONO) begin
            if (step_r > m_peak_r) m_peak_r <= step_r;
            if (m_cnt_r != '1) begin
              m_sum_r <= m_sum_r + 64'(sq_r);
              m_cnt_r <= m_cnt_r + 32'd1;
            end
          end else begin
            if (step_r > s_peak_r) s_peak_r <= step_r;
            if (s_cnt_r != '1) begin
              s_sum_r <= s_sum_r + 64'(sq_r);
              s_cnt_r <= s_cnt_r + 32'd1;
            end
          end
        end
        ST_MED_RDI: ;
        ST_MED_PIV: begin
          s_piv_r  <= s_rd_r;
          m_piv_r  <= m_rd_r;
          j_r      <= '0;
          s_less_r <= '0;
          s_leq_r  <= '0;
          m_less_r <= '0;
          m_leq_r  <= '0;
        end
        ST_MED_RDJ: ;
        ST_MED_CMP: begin
          if (s_rd_r < s_piv_r)  s_less_r <= s_less_r + 1'b1;
          if (s_rd_r <= s_piv_r) s_leq_r  <= s_leq_r + 1'b1;
          if (m_rd_r < m_piv_r)  m_less_r <= m_less_r + 1'b1;
          if (m_rd_r <= m_piv_r) m_leq_r  <= m_leq_r + 1'b1;
          if (!j_last) j_r <= j_r + 1'b1;
        end
        ST_MED_CHK: begin
          if (s_hit) begin
            s_found_r <= 1'b1;
            s_med_r   <= s_piv_r;
          end
          if (m_hit) begin
            m_found_r <= 1'b1;
            m_med_r   <= m_piv_r;
          end
          if (!i_last) i_r <= i_r + 1'b1;
        end
        ST_ANOM_MUL: begin
          s_prod_r <= s_med_r * ratio_r;
          m_prod_r <= m_med_r * ratio_r;
        end
        ST_ANOM_CMP: begin
          s_anom_r <= (fill_r >= CNT_W'(WINDOW_FRAMES / 2)) &&
                      (((24'(s_peak_r) > s_prod_r) && (s_peak_r > soft_r)) ||
                       (s_peak_r > hard_r));
          m_anom_r <= (fill_r >= CNT_W'(WINDOW_FRAMES / 2)) &&
                      (((24'(m_peak_r) > m_prod_r) && (m_peak_r > soft_r)) ||
                       (m_peak_r > hard_r));
          div_sel_r <= 1'b0;
        end
        ST_DIV_INIT: begin
          dvd_r  <= div_sel_r ? m_sum_r : s_sum_r;
          dsr_r  <= cur_cnt;
          rem_r  <= '0;
          dcnt_r <= '0;
          if (cur_cnt == '0) begin
            if (div_sel_r) m_ms_r <= '0;
            else s_ms_r <= '0;
            div_sel_r <= 1'b1;
          end
        end
        ST_DIV_RUN: begin
          rem_r  <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
          dvd_r  <= dvd_shift;
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd63) begin
            if (div_sel_r) m_ms_r <= dvd_shift[31:0];
            else s_ms_r <= dvd_shift[31:0];
            div_sel_r <= 1'b1;
          end
        end
        ST_RING_WR: begin
          head_r <= (head_r == IDX_W'(WINDOW_FRAMES - 1)) ? '0 : head_r + 1'b1;
          if (fill_r < CNT_W'(WINDOW_FRAMES)) fill_r <= fill_r + 1'b1;
        end
        ST_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= {6'd0, m_ms_r, s_ms_r, m_med_r, s_med_r,
                             m_peak_r, s_peak_r, m_anom_r, s_anom_r};
            s_peak_r <= '0;
            m_peak_r <= '0;
            s_sum_r  <= '0;
            m_sum_r  <= '0;
            s_cnt_r  <= '0;
            m_cnt_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  `ACD_ASSERT_ALWAYS(a_fill_bound, fill_r <= CNT_W'(WINDOW_FRAMES), "ring fill beyond window")
  `ACD_ASSERT_ALWAYS(a_head_bound, head_r <= IDX_W'(WINDOW_FRAMES - 1), "ring head out of range")
  `ACD_ASSERT_NEXT(a_ring_push, state_r == ST_RING_WR && fill_r < CNT_W'(WINDOW_FRAMES), fill_r == $past(fill_r) + 1'b1, "ring fill not advanced")
  `ACD_ASSERT_NEXT(a_div_end, state_r == ST_DIV_RUN && dcnt_r == 6'd63 && !div_sel_r, state_r == ST_DIV_INIT && div_sel_r, "second division not started")

endmodule

// File: verif/tb_audio_click_detector_top.sv
// self-checking testbench for audio_click_detector_top: stream stimulus, frame result check
// depends on acd_pkg and the click detector rtl; predictor lives in a small scoreboard class
module tb_audio_click_detector_top;
  timeunit 1ns;
  timeprecision 1ps;
  import acd_pkg::*;

  localparam int RING_DEPTH = 120;
  localparam int WATCHDOG_LIMIT = 100000;

  typedef struct {
    bit          s_anom;
    bit          m_anom;
    bit [15:0]   s_peak;
    bit [15:0]   m_peak;
    bit [15:0]   s_med;
    bit [15:0]   m_med;
    bit [31:0]   s_ms;
    bit [31:0]   m_ms;
  } frame_result_t;

  class click_scoreboard;
    bit               en;
    bit [7:0]         ratio;
    bit [15:0]        soft_thr;
    bit [15:0]        hard;
    int               last_l, last_r, last_m;
    bit               s_primed, m_primed;
    int unsigned      s_peak, m_peak, s_cnt, m_cnt;
    longint unsigned  s_sum, m_sum;
    bit [15:0]        s_ring[RING_DEPTH];
    bit [15:0]        m_ring[RING_DEPTH];
    int               head, fill;
    frame_result_t    pending[$];
    int               errors;

    function new();
      en = 1;
      ratio = RATIO_RST;
      soft_thr = SOFT_RST;
      hard = HARD_RST;
      errors = 0;
      clear_all();
    endfunction

    function void clear_all();
      last_l = 0; last_r = 0; last_m = 0;
      s_primed = 0; m_primed = 0;
      s_peak = 0; m_peak = 0; s_cnt = 0; m_cnt = 0; s_sum = 0; m_sum = 0;
      foreach (s_ring[i]) begin
        s_ring[i] = 0;
        m_ring[i] = 0;
      end
      head = 0;
      fill = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_ENABLE: en = val[0];
        REG_RATIO:  ratio = val[7:0];
        REG_SOFT:   soft_thr = val;
        REG_HARD:   hard = val;
      endcase
    endfunction

    function void accumulate(int unsigned d, inout int unsigned pk,
                             inout longint unsigned sm, inout int unsigned cn);
      if (d > pk) pk = d;
      if (cn != 32'hFFFF_FFFF) begin
        sm += longint'(d) * longint'(d);
        cn++;
      end
    endfunction

    function bit [15:0] median_of(bit [15:0] ring[RING_DEPTH]);
      bit [15:0] q[$];
      for (int i = 0; i < fill; i++) q.push_back(ring[i]);
      q.sort();
      return (fill == 0) ? 16'd0 : q[fill / 2];
    endfunction

    function bit flag_of(int unsigned pk, int unsigned med);
      if (fill < RING_DEPTH / 2) return 0;
      if (pk > med * ratio && pk > soft_thr) return 1;
      return pk > hard;
    endfunction

    function void note_word(logic [1:0] cmd, logic signed [15:0] l, logic signed [15:0] r);
      int            li, ri, dl, dr;
      frame_result_t res;
      li = l;
      ri = r;
      case (cmd)
        CMD_CLEAR: clear_all();
        CMD_STEREO: if (en) begin
          if (s_primed) begin
            dl = (li > last_l) ? li - last_l : last_l - li;
            dr = (ri > last_r) ? ri - last_r : last_r - ri;
            accumulate((dl > dr) ? dl : dr, s_peak, s_sum, s_cnt);
          end
          last_l = li;
          last_r = ri;
          s_primed = 1;
        end
        CMD_MONO: if (en) begin
          if (m_primed) begin
            dl = (li > last_m) ? li - last_m : last_m - li;
            accumulate(dl, m_peak, m_sum, m_cnt);
          end
          last_m = li;
          m_primed = 1;
        end
        default: begin
          if (en) begin
            res.s_peak = s_peak[15:0];
            res.m_peak = m_peak[15:0];
            res.s_med = median_of(s_ring);
            res.m_med = median_of(m_ring);
            res.s_anom = flag_of(res.s_peak, res.s_med);
            res.m_anom = flag_of(res.m_peak, res.m_med);
            res.s_ms = (s_cnt == 0) ? 32'd0 : 32'(s_sum / s_cnt);
            res.m_ms = (m_cnt == 0) ? 32'd0 : 32'(m_sum / m_cnt);
            pending.push_back(res);
            s_ring[head] = res.s_peak;
            m_ring[head] = res.m_peak;
            head = (head + 1) % RING_DEPTH;
            if (fill < RING_DEPTH) fill++;
          end
          s_peak = 0; m_peak = 0; s_cnt = 0; m_cnt = 0; s_sum = 0; m_sum = 0;
        end
      endcase
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, exp_v, act_v);
      end
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] d);
      frame_result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual %h", $realtime, d);
        return;
      end
      e = pending.pop_front();
      compare_field("stereo_anomaly", e.s_anom, d[0]);
      compare_field("mono_anomaly", e.m_anom, d[1]);
      compare_field("stereo_peak", e.s_peak, d[17:2]);
      compare_field("mono_peak", e.m_peak, d[33:18]);
      compare_field("stereo_median", e.s_med, d[49:34]);
      compare_field("mono_median", e.m_med, d[65:50]);
      compare_field("stereo_mean_square", e.s_ms, d[97:66]);
      compare_field("mono_mean_square", e.m_ms, d[129:98]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [15:0]           cfg_wdata;

  click_scoreboard sb;
  bit  calm;
  bit  hold_req;
  int  idle_cycles;
  int  prev_l, prev_r, prev_m;

  audio_click_detector_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (3000) @(negedge clk);
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(logic [1:0] cmd, logic [15:0] l, logic [15:0] r);
    if (!calm && $urandom_range(0, 99) < 15) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {r, l};
    do @(posedge clk); while (!in_tready);
    sb.note_word(cmd, l, r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_thresholds(logic [7:0] ratio, logic [15:0] soft_v, logic [15:0] hard);
    write_reg(REG_RATIO, {8'd0, ratio});
    write_reg(REG_SOFT, soft_v);
    write_reg(REG_HARD, hard);
  endtask

  function automatic logic [15:0] next_sample(int prev);
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return 16'(prev + $urandom_range(0, 600) - 300);
  endfunction

  task automatic send_random_sample(bit big);
    logic [15:0] l, r;
    if ($urandom_range(0, 1)) begin
      l = big ? 16'($urandom) : next_sample(prev_l);
      r = big ? 16'($urandom) : next_sample(prev_r);
      prev_l = $signed(l);
      prev_r = $signed(r);
      send_word(CMD_STEREO, l, r);
    end else begin
      l = big ? 16'($urandom) : next_sample(prev_m);
      prev_m = $signed(l);
      send_word(CMD_MONO, l, 16'($urandom));
    end
  endtask

  task automatic send_frame(int n_samples, bit spike);
    for (int i = 0; i < n_samples; i++) send_random_sample(spike && i == n_samples - 1);
    send_word(CMD_TICK, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    sb = new();
    calm = 0;
    hold_req = 0;
    idle_cycles = 0;
    prev_l = 0; prev_r = 0; prev_m = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_STEREO;
    cfg_we = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty tick, extreme steps, clear, disabled behavior
    send_word(CMD_TICK, 16'h0000, 16'h0000);
    send_word(CMD_STEREO, 16'h0000, 16'h0000);
    send_word(CMD_STEREO, 16'h7FFF, 16'h8000);
    send_word(CMD_STEREO, 16'h8000, 16'h7FFF);
    send_word(CMD_MONO, 16'h8000, 16'hFFFF);
    send_word(CMD_MONO, 16'h7FFF, 16'h0000);
    send_word(CMD_MONO, 16'h0000, 16'h1234);
    send_word(CMD_TICK, 16'hFFFF, 16'hFFFF);
    send_word(CMD_STEREO, 16'h0005, 16'hFFFB);
    send_word(CMD_MONO, 16'hFFFF, 16'h0000);
    send_word(CMD_CLEAR, 16'hAAAA, 16'h5555);
    send_word(CMD_STEREO, 16'h0010, 16'h0010);
    send_word(CMD_TICK, 16'h0000, 16'h0000);
    write_reg(REG_ENABLE, 16'd0);
    send_word(CMD_STEREO, 16'h0100, 16'h0100);
    send_word(CMD_MONO, 16'h0200, 16'h0000);
    send_word(CMD_TICK, 16'h0000, 16'h0000);
    send_word(CMD_CLEAR, 16'h0000, 16'h0000);
    write_reg(REG_ENABLE, 16'd1);
    send_word(CMD_STEREO, 16'h0064, 16'hFF9C);
    send_word(CMD_MONO, 16'h0064, 16'h0000);
    send_word(CMD_TICK, 16'h0000, 16'h0000);

    // fill the ring past half with quiet frames, spikes now and then
    for (int f = 0; f < 70; f++) begin
      if (f == 2) begin
        drain();
        hold_req = 1;
        send_frame(3, 0);
        send_frame(2, 1);
        send_frame(1, 0);
        drain();
      end
      case (f)
        56: set_thresholds(8'd255, 16'd0, 16'hFFFF);
        61: set_thresholds(8'd1, 16'd0, 16'hFFFF);
        64: set_thresholds(8'd8, 16'hFFFF, 16'd0);
        67: set_thresholds(8'd2, 16'd500, 16'd3000);
        default: ;
      endcase
      send_frame($urandom_range(2, 5), $urandom_range(0, 4) == 0);
    end

    write_reg(REG_ENABLE, 16'd1);
    send_word(CMD_CLEAR, 16'($urandom), 16'($urandom));
    set_thresholds(RATIO_RST, SOFT_RST, HARD_RST);

    // random mix of samples, ticks and clears, with register writes every 110 items
    calm = 1;
    for (int i = 0; i < 330; i++) begin
      int pick;
      if (i == 150) calm = 0;
      if (i % 110 == 109) begin
        write_reg(REG_ENABLE, 16'($urandom_range(0, 3) != 0));
        set_thresholds(8'($urandom_range(1, 255)), 16'($urandom), 16'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 86) send_random_sample(0);
      else if (pick < 96) send_word(CMD_TICK, 16'($urandom), 16'($urandom));
      else send_word(CMD_CLEAR, 16'($urandom), 16'($urandom));
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
